[src/ftob_pkg.sv]
// Package for the feathered tile overlap blend unit.
// Holds opcodes, register indexes, reset values and limits; depends on nothing.
`default_nettype none
package ftob_pkg;

  // Item opcodes.
  typedef enum logic {
    OP_BLEND = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // Configuration register indexes (byte address is 4 times the index).
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CORE_WIDTH   = 2'd2,
    REG_CORE_HEIGHT  = 2'd3
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd2048;
  localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd2048;
  localparam logic [10:0] CORE_WIDTH_RST   = 11'd1280;
  localparam logic [10:0] CORE_HEIGHT_RST  = 11'd1280;

  // Largest weight sum that the store can hold.
  localparam logic [14:0] WEIGHT_MAX = 15'h7FFF;

endpackage
`default_nettype wire

[src/ftob_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the pixel and weight store; depends on nothing.
`default_nettype none
module ftob_ram #(
  parameter int WIDTH = 47,
  parameter int DEPTH = 4194304
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/feathered_tile_overlap_blend_unit.sv]
// Top level of the feathered tile overlap blend unit: weight ramps, store
// read-modify-write and the pipelined divider. Depends on ftob_pkg, ftob_ram.
//
//   channel  direction  signals                                   handshake
//   item     in         start_i, opcode_i, pos/origin, in_rgba    start_i & !busy_o
//   result   out        done_o, out_rgba, weight_sum_o, applied_o done_o, one cycle
//   config   in/out     psel, penable, pwrite, paddr, pwdata      APB, pready high
//
// One item is taken per cycle while busy_o is low. Its result beat passes through the
// two front stages (the store read lands in the second), the sum stage, the eight-step
// divider pipeline and the result register, in that order.
// busy_o is high while an item at the same pixel position is still in flight,
// since that store entry is read before the earlier item writes it back.
// After reset a clearing pass writes zero to every store entry, one a cycle, and
// busy_o is high meanwhile.
// The receiver cannot stall: each result beat is valid for one cycle.
`default_nettype none
module feathered_tile_overlap_blend_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int OVERLAP    = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        opcode_i,
  input  wire logic [10:0] pos_x_i,
  input  wire logic [10:0] pos_y_i,
  input  wire logic [10:0] origin_x_i,
  input  wire logic [10:0] origin_y_i,
  input  wire logic [7:0]  in_red_i,
  input  wire logic [7:0]  in_green_i,
  input  wire logic [7:0]  in_blue_i,
  input  wire logic [7:0]  in_alpha_i,
  output logic             done_o,
  output logic      [7:0]  out_red_o,
  output logic      [7:0]  out_green_o,
  output logic      [7:0]  out_blue_o,
  output logic      [7:0]  out_alpha_o,
  output logic      [14:0] weight_sum_o,
  output logic             applied_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIMW  = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(OVERLAP + 1);
  localparam int WTW   = 2 * RW;
  localparam int SUMW  = ((WTW > 15) ? WTW : 15) + 1;
  localparam int NUMW  = 8 + SUMW;
  localparam int DW    = NUMW + 2;
  localparam int NDIV  = 8;
  localparam int LAT   = NDIV + 4;
  localparam int RAMW  = 47;

  // Front stage record: decoded item before the store read.
  typedef struct packed {
    logic          blend;
    logic          in_img;
    logic [10:0]   px;
    logic [10:0]   py;
    logic [AW-1:0] addr;
    logic [WTW-1:0] wt;
    logic [31:0]   rgba;
  } front_t;

  // Divider stage record.
  typedef struct packed {
    logic                  in_img;
    logic                  app;
    logic [10:0]           px;
    logic [10:0]           py;
    logic [AW-1:0]         addr;
    logic [14:0]           wsum_old;
    logic [31:0]           pix_old;
    logic [SUMW-1:0]       sum;
    logic [SUMW:0]         vdiv;
    logic [3:0][DW-1:0]    rem;
    logic [3:0][7:0]       quo;
  } div_t;

  // Linear edge ramp along one axis.
  function automatic logic [RW-1:0] ramp_f(input logic [10:0] p, input logic [10:0] o,
                                           input logic [10:0] core);
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] r;
    a = $signed({5'd0, p}) - $signed({5'd0, o}) + 16'(OVERLAP + 1);
    b = $signed({5'd0, o}) + $signed({5'd0, core}) + 16'(OVERLAP) - $signed({5'd0, p});
    r = 16'(OVERLAP);
    if (a < r) r = a;
    if (b < r) r = b;
    return (r > 0) ? RW'(r) : '0;
  endfunction

  // Configuration registers.
  logic [11:0] img_w_q, img_h_q;
  logic [10:0] core_w_q, core_h_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= ftob_pkg::IMAGE_WIDTH_RST;
      img_h_q  <= ftob_pkg::IMAGE_HEIGHT_RST;
      core_w_q <= ftob_pkg::CORE_WIDTH_RST;
      core_h_q <= ftob_pkg::CORE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (ftob_pkg::reg_idx_e'(paddr[3:2]))
        ftob_pkg::REG_IMAGE_WIDTH:  img_w_q  <= pwdata[11:0];
        ftob_pkg::REG_IMAGE_HEIGHT: img_h_q  <= pwdata[11:0];
        ftob_pkg::REG_CORE_WIDTH:   core_w_q <= pwdata[10:0];
        ftob_pkg::REG_CORE_HEIGHT:  core_h_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (ftob_pkg::reg_idx_e'(paddr[3:2]))
      ftob_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, img_w_q};
      ftob_pkg::REG_IMAGE_HEIGHT: prdata = {20'd0, img_h_q};
      ftob_pkg::REG_CORE_WIDTH:   prdata = {21'd0, core_w_q};
      ftob_pkg::REG_CORE_HEIGHT:  prdata = {21'd0, core_h_q};
      default:                    prdata = '0;
    endcase
  end

  // Effective dimensions after clamping.
  logic [DIMW-1:0] dim_w, dim_h;
  logic [10:0]     core_w, core_h;

  always_comb begin
    if (img_w_q == 12'd0)                    dim_w = DIMW'(1);
    else if (32'(img_w_q) > 32'(MAX_WIDTH))  dim_w = DIMW'(MAX_WIDTH);
    else                                     dim_w = DIMW'(img_w_q);
    if (img_h_q == 12'd0)                    dim_h = DIMW'(1);
    else if (32'(img_h_q) > 32'(MAX_HEIGHT)) dim_h = DIMW'(MAX_HEIGHT);
    else                                     dim_h = DIMW'(img_h_q);
    core_w = (core_w_q == 11'd0) ? 11'd1 : core_w_q;
    core_h = (core_h_q == 11'd0) ? 11'd1 : core_h_q;
  end

  // Clearing pass over the store after reset.
  logic          clear_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) clear_q <= 1'b0;
    end
  end

  // Pipeline valid bits and records.
  logic                 f1_vld_q, f2_vld_q;
  front_t               f1_q, f2_q, f1_d;
  logic [NDIV:0]        dv_vld_q;
  div_t                 dv_q [NDIV+1];
  div_t                 dv0_d;
  logic                 accept;
  logic                 hazard;

  // Same position still in flight: hold the new beat off.
  always_comb begin
    hazard = (f1_vld_q && f1_q.px == pos_x_i && f1_q.py == pos_y_i) ||
             (f2_vld_q && f2_q.px == pos_x_i && f2_q.py == pos_y_i);
    for (int k = 0; k <= NDIV; k++) begin
      if (dv_vld_q[k] && dv_q[k].px == pos_x_i && dv_q[k].py == pos_y_i) hazard = 1'b1;
    end
  end

  assign busy_o = clear_q || hazard;
  assign accept = start_i && !busy_o;

  // Decode: address, in-image test and weight.
  logic [11+DIMW-1:0] row_base;
  logic [RW-1:0]      ramp_x, ramp_y;

  always_comb begin
    row_base     = (11+DIMW)'(pos_y_i) * (11+DIMW)'(dim_w);
    ramp_x       = ramp_f(pos_x_i, origin_x_i, core_w);
    ramp_y       = ramp_f(pos_y_i, origin_y_i, core_h);
    f1_d.blend   = (ftob_pkg::opcode_e'(opcode_i) == ftob_pkg::OP_BLEND);
    f1_d.in_img  = (32'(pos_x_i) < 32'(dim_w)) && (32'(pos_y_i) < 32'(dim_h));
    f1_d.px      = pos_x_i;
    f1_d.py      = pos_y_i;
    f1_d.addr    = AW'(row_base + (11+DIMW)'(pos_x_i));
    f1_d.wt      = WTW'(ramp_x) * WTW'(ramp_y);
    f1_d.rgba    = {in_alpha_i, in_blue_i, in_green_i, in_red_i};
  end

  // Store read; data lands with the second front stage.
  logic [RAMW-1:0] rd_data;
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [RAMW-1:0] st_wdata;
  logic [14:0]     sat_sum;

  ftob_ram #(.WIDTH(RAMW), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (f1_vld_q && f1_q.in_img),
    .raddr_i (f1_q.addr),
    .rdata_o (rd_data)
  );

  // Weighted sums from the stored entry.
  always_comb begin
    logic [14:0] wold;
    wold            = rd_data[46:32] & ftob_pkg::WEIGHT_MAX;
    dv0_d.in_img    = f2_q.in_img;
    dv0_d.app       = f2_q.in_img && f2_q.blend && (f2_q.wt != '0);
    dv0_d.px        = f2_q.px;
    dv0_d.py        = f2_q.py;
    dv0_d.addr      = f2_q.addr;
    dv0_d.wsum_old  = wold;
    dv0_d.pix_old   = rd_data[31:0];
    dv0_d.sum       = SUMW'(wold) + SUMW'(f2_q.wt);
    dv0_d.vdiv      = {dv0_d.sum, 1'b0};
    dv0_d.quo       = '0;
    for (int c = 0; c < 4; c++) begin
      dv0_d.rem[c] = DW'({(NUMW'(rd_data[8*c +: 8]) * NUMW'(wold) +
                           NUMW'(f2_q.rgba[8*c +: 8]) * NUMW'(f2_q.wt)), 1'b0}) +
                     DW'(dv0_d.sum);
    end
  end

  // Front and sum stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q    <= 1'b0;
      f2_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else begin
      f1_vld_q    <= accept;
      f2_vld_q    <= f1_vld_q;
      dv_vld_q[0] <= f2_vld_q;
    end
  end

  // Front and sum stage payload.
  always_ff @(posedge clk_i) begin
    f1_q     <= f1_d;
    f2_q     <= f1_q;
    dv_q[0]  <= dv0_d;
  end

  // Restoring divider, one quotient bit per stage, four channels side by side.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int BIT = NDIV - 1 - k;
    div_t step_d;

    always_comb begin
      logic [DW-1:0] trial;
      step_d = dv_q[k];
      trial  = DW'(dv_q[k].vdiv) << BIT;
      for (int c = 0; c < 4; c++) begin
        if (dv_q[k].rem[c] >= trial) begin
          step_d.rem[c]      = dv_q[k].rem[c] - trial;
          step_d.quo[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= step_d;
    end
  end

  // Write-back of the blended entry, or zero during the clearing pass.
  always_comb begin
    sat_sum = (dv_q[NDIV].sum > SUMW'(ftob_pkg::WEIGHT_MAX)) ? ftob_pkg::WEIGHT_MAX
                                                             : dv_q[NDIV].sum[14:0];
    if (clear_q) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_q;
      st_wdata = '0;
    end else begin
      st_we    = dv_vld_q[NDIV] && dv_q[NDIV].app;
      st_waddr = dv_q[NDIV].addr;
      st_wdata = {sat_sum, dv_q[NDIV].quo};
    end
  end

  // Result beat.
  logic        done_q;
  logic [31:0] res_pix_q, res_pix_d;
  logic [14:0] res_wsum_q, res_wsum_d;
  logic        res_app_q;

  always_comb begin
    if (!dv_q[NDIV].in_img) begin
      res_pix_d  = '0;
      res_wsum_d = '0;
    end else if (dv_q[NDIV].app) begin
      res_pix_d  = dv_q[NDIV].quo;
      res_wsum_d = sat_sum;
    end else begin
      res_pix_d  = dv_q[NDIV].pix_old;
      res_wsum_d = dv_q[NDIV].wsum_old;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    res_pix_q  <= res_pix_d;
    res_wsum_q <= res_wsum_d;
    res_app_q  <= dv_q[NDIV].app;
  end

  assign done_o       = done_q;
  assign out_red_o    = res_pix_q[7:0];
  assign out_green_o  = res_pix_q[15:8];
  assign out_blue_o   = res_pix_q[23:16];
  assign out_alpha_o  = res_pix_q[31:24];
  assign weight_sum_o = res_wsum_q;
  assign applied_o    = done_q && res_app_q;

  // Checks on the pipeline and the clearing pass.
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !accept) else $error("item accepted during clearing pass");

  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o) else $error("result beat missing after accept");

  a_applied_has_weight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    applied_o |-> (weight_sum_o != 15'd0)) else $error("applied beat with zero weight");

  a_no_write_while_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !(dv_vld_q[NDIV] && dv_q[NDIV].app))
    else $error("blend write-back during clearing pass");

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the feathered tile overlap blend unit.
// It drives pixel beats and APB writes and checks every result against its own store model.
// Depends on ftob_pkg and feathered_tile_overlap_blend_unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_W = 2048;
  localparam int LIMIT_H = 2048;
  localparam int RAMP_LEN = 64;
  localparam int LATENCY = 12;

  typedef struct {
    ftob_pkg::opcode_e op;
    logic [10:0]  px, py, ox, oy;
    logic [7:0]   chan [4];
  } pixel_beat_t;

  typedef struct {
    logic [7:0]  chan [4];
    logic [14:0] wsum;
    logic        applied;
  } blend_out_t;

  typedef struct {
    pixel_beat_t beat;
    bit          typed;
    blend_out_t  want;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        opcode_i = 1'b0;
  logic [10:0] pos_x_i = '0, pos_y_i = '0, origin_x_i = '0, origin_y_i = '0;
  logic [7:0]  in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic        done_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic [14:0] weight_sum_o;
  logic        applied_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  feathered_tile_overlap_blend_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .pos_x_i, .pos_y_i,
    .origin_x_i, .origin_y_i, .in_red_i, .in_green_i, .in_blue_i, .in_alpha_i,
    .done_o, .out_red_o, .out_green_o, .out_blue_o, .out_alpha_o,
    .weight_sum_o, .applied_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Model of the configuration and of both stores; unwritten entries read as zero.
  logic [11:0] img_w_reg = ftob_pkg::IMAGE_WIDTH_RST, img_h_reg = ftob_pkg::IMAGE_HEIGHT_RST;
  logic [10:0] core_w_reg = ftob_pkg::CORE_WIDTH_RST, core_h_reg = ftob_pkg::CORE_HEIGHT_RST;
  logic [31:0] pixel_mem [int];
  logic [14:0] weight_mem [int];
  blend_out_t  pending_results [$];
  int          errors = 0;
  bit          idle_enable = 1'b1;

  function automatic int eff_width();
    return img_w_reg == 0 ? 1 : (img_w_reg > LIMIT_W ? LIMIT_W : int'(img_w_reg));
  endfunction

  function automatic int eff_height();
    return img_h_reg == 0 ? 1 : (img_h_reg > LIMIT_H ? LIMIT_H : int'(img_h_reg));
  endfunction

  function automatic longint edge_ramp(int p, int o, int c);
    longint r, a, b;
    r = RAMP_LEN;
    a = p - o + RAMP_LEN + 1;
    b = o + c + RAMP_LEN - p;
    if (a < r) r = a;
    if (b < r) r = b;
    return r > 0 ? r : 0;
  endfunction

  // Works out the result of one accepted beat and updates the store model.
  function automatic blend_out_t blend_predict(pixel_beat_t b);
    blend_out_t res;
    int w, h, cw, ch, addr;
    longint wt, wold, total, num, q;
    logic [31:0] pix, np;
    w = eff_width();
    h = eff_height();
    cw = core_w_reg == 0 ? 1 : int'(core_w_reg);
    ch = core_h_reg == 0 ? 1 : int'(core_h_reg);
    res.applied = 1'b0;
    if (b.px >= w || b.py >= h) begin
      for (int c = 0; c < 4; c++) res.chan[c] = '0;
      res.wsum = '0;
      return res;
    end
    addr = int'(b.py) * w + int'(b.px);
    pix = pixel_mem.exists(addr) ? pixel_mem[addr] : '0;
    wold = weight_mem.exists(addr) ? longint'(weight_mem[addr]) : 0;
    if (b.op == ftob_pkg::OP_BLEND) begin
      wt = edge_ramp(b.px, b.ox, cw) * edge_ramp(b.py, b.oy, ch);
      if (wt != 0) begin
        total = wold + wt;
        np = '0;
        for (int c = 0; c < 4; c++) begin
          num = longint'(pix[8*c +: 8]) * wold + longint'(b.chan[c]) * wt;
          q = (2 * num + total) / (2 * total);
          if (q > 255) q = 255;
          np[8*c +: 8] = q[7:0];
        end
        pix = np;
        wold = total > ftob_pkg::WEIGHT_MAX ? longint'(ftob_pkg::WEIGHT_MAX) : total;
        pixel_mem[addr] = pix;
        weight_mem[addr] = wold[14:0];
        res.applied = 1'b1;
      end
    end
    for (int c = 0; c < 4; c++) res.chan[c] = pix[8*c +: 8];
    res.wsum = wold[14:0];
    return res;
  endfunction

  // Result checker: each done beat is matched with the oldest expectation.
  always @(posedge clk_i) begin
    blend_out_t got, want;
    if (rst_ni && done_o) begin
      got.chan[0] = out_red_o;
      got.chan[1] = out_green_o;
      got.chan[2] = out_blue_o;
      got.chan[3] = out_alpha_o;
      got.wsum = weight_sum_o;
      got.applied = applied_o;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rgba %p wsum %0d applied %0b",
                 $time, got.chan, got.wsum, got.applied);
        errors++;
      end else begin
        want = pending_results.pop_front();
        for (int c = 0; c < 4; c++)
          if (got.chan[c] !== want.chan[c]) begin
            $display("%0t: channel %0d expected %0d actual %0d", $time, c,
                     want.chan[c], got.chan[c]);
            errors++;
          end
        if (got.wsum !== want.wsum) begin
          $display("%0t: weight_sum expected %0d actual %0d", $time, want.wsum, got.wsum);
          errors++;
        end
        if (got.applied !== want.applied) begin
          $display("%0t: applied expected %0b actual %0b", $time, want.applied,
                   got.applied);
          errors++;
        end
      end
    end
  end

  // APB register write: setup cycle, then access cycle.
  task automatic reg_write(ftob_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ftob_pkg::REG_IMAGE_WIDTH:  img_w_reg = val[11:0];
      ftob_pkg::REG_IMAGE_HEIGHT: img_h_reg = val[11:0];
      ftob_pkg::REG_CORE_WIDTH:   core_w_reg = val[10:0];
      ftob_pkg::REG_CORE_HEIGHT:  core_h_reg = val[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drops start, then waits until every expected result has come, and longer still than the pipeline depth.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Sends one pixel beat; start stays high into the next beat unless a gap follows.
  task automatic send_beat(pixel_beat_t b, output blend_out_t pred);
    int gap;
    @(negedge clk_i);
    start_i = 1'b1;
    opcode_i = b.op;
    pos_x_i = b.px;
    pos_y_i = b.py;
    origin_x_i = b.ox;
    origin_y_i = b.oy;
    in_red_i = b.chan[0];
    in_green_i = b.chan[1];
    in_blue_i = b.chan[2];
    in_alpha_i = b.chan[3];
    do @(posedge clk_i); while (busy_o);
    pred = blend_predict(b);
    pending_results.push_back(pred);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 19));
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic int clip_pos(int v);
    return v < 0 ? 0 : (v > 2047 ? 2047 : v);
  endfunction

  // Random beat: mostly pixels clustered near the image corner with tile origins around them, some pure noise.
  function automatic pixel_beat_t random_beat();
    pixel_beat_t b;
    int w, h, cw, ch, spanx, spany;
    w = eff_width();
    h = eff_height();
    cw = core_w_reg == 0 ? 1 : int'(core_w_reg);
    ch = core_h_reg == 0 ? 1 : int'(core_h_reg);
    b.op = $urandom_range(0, 4) == 0 ? ftob_pkg::OP_READ : ftob_pkg::OP_BLEND;
    for (int c = 0; c < 4; c++) b.chan[c] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      b.px = 11'($urandom);
      b.py = 11'($urandom);
      b.ox = 11'($urandom);
      b.oy = 11'($urandom);
    end else begin
      spanx = w < 20 ? w : 20;
      spany = h < 20 ? h : 20;
      b.px = 11'($urandom_range(0, spanx));
      b.py = 11'($urandom_range(0, spany));
      b.ox = 11'(clip_pos(int'(b.px) + RAMP_LEN -
                          int'($urandom_range(0, (cw > 200 ? 200 : cw) + 130))));
      b.oy = 11'(clip_pos(int'(b.py) + RAMP_LEN -
                          int'($urandom_range(0, (ch > 200 ? 200 : ch) + 130))));
    end
    return b;
  endfunction

  function automatic table_row_t mk_row(ftob_pkg::opcode_e op, int px, int py, int ox,
                                        int oy, int r, int g, int bl, int a, bit typed,
                                        int wsum, bit applied);
    table_row_t t;
    t.beat.op = op;
    t.beat.px = 11'(px);
    t.beat.py = 11'(py);
    t.beat.ox = 11'(ox);
    t.beat.oy = 11'(oy);
    t.beat.chan[0] = 8'(r);
    t.beat.chan[1] = 8'(g);
    t.beat.chan[2] = 8'(bl);
    t.beat.chan[3] = 8'(a);
    t.typed = typed;
    t.want.chan[0] = 8'(typed && wsum != 0 ? r : 0);
    t.want.chan[1] = 8'(typed && wsum != 0 ? g : 0);
    t.want.chan[2] = 8'(typed && wsum != 0 ? bl : 0);
    t.want.chan[3] = 8'(typed && wsum != 0 ? a : 0);
    t.want.wsum = 15'(wsum);
    t.want.applied = applied;
    return t;
  endfunction

  task automatic run_random(int count, int pause_at);
    blend_out_t pred;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send_beat(random_beat(), pred);
    end
  endtask

  // Main stimulus.
  initial begin
    table_row_t  rows [$];
    blend_out_t  pred;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The store clearing pass holds busy high; wait it out.
    do @(posedge clk_i); while (busy_o);

    // Directed part at reset settings: extremes, both opcodes, zero weight.
    rows.push_back(mk_row(ftob_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 0, 0, 0, 0, 255, 0, 170, 85, 1, 4096, 1));
    rows.push_back(mk_row(ftob_pkg::OP_READ, 0, 0, 2047, 2047, 255, 0, 170, 85, 1, 4096, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 2047, 2047, 0, 0, 255, 255, 255, 255, 1, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 0, 0, 0, 0, 0, 255, 85, 170, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 0, 0, 0, 0, 255, 255, 255, 255, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 2047, 2047, 2047, 2047, 1, 2, 3, 4, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 1343, 5, 0, 0, 9, 9, 9, 9, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 1344, 5, 0, 0, 9, 9, 9, 9, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 100, 100, 163, 100, 200, 100, 50, 25, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 100, 100, 164, 100, 200, 100, 50, 25, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_BLEND, 100, 100, 100, 100, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 8; k++)
      rows.push_back(mk_row(ftob_pkg::OP_BLEND, 7, 7, 7, 7, 255, 1, 128, 0, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_READ, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ftob_pkg::OP_READ, 2047, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) begin
      send_beat(rows[i].beat, pred);
      if (rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(rows[i].want);
      end
    end
    run_random(180, 90);

    // Every register clamped to its minimum use.
    drain();
    reg_write(ftob_pkg::REG_IMAGE_WIDTH, 32'd0);
    reg_write(ftob_pkg::REG_IMAGE_HEIGHT, 32'd0);
    reg_write(ftob_pkg::REG_CORE_WIDTH, 32'd0);
    reg_write(ftob_pkg::REG_CORE_HEIGHT, 32'd0);
    run_random(200, -1);

    // Every register at its largest field value.
    drain();
    reg_write(ftob_pkg::REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    reg_write(ftob_pkg::REG_IMAGE_HEIGHT, 32'h0000_0FFF);
    reg_write(ftob_pkg::REG_CORE_WIDTH, 32'hFFFF_FFFF);
    reg_write(ftob_pkg::REG_CORE_HEIGHT, 32'h0000_07FF);
    run_random(200, -1);

    // Small odd image with tiny cores.
    drain();
    reg_write(ftob_pkg::REG_IMAGE_WIDTH, 32'd37);
    reg_write(ftob_pkg::REG_IMAGE_HEIGHT, 32'd23);
    reg_write(ftob_pkg::REG_CORE_WIDTH, 32'd5);
    reg_write(ftob_pkg::REG_CORE_HEIGHT, 32'd3);
    run_random(220, -1);

    // One-row image.
    drain();
    reg_write(ftob_pkg::REG_IMAGE_WIDTH, 32'd2048);
    reg_write(ftob_pkg::REG_IMAGE_HEIGHT, 32'd1);
    reg_write(ftob_pkg::REG_CORE_WIDTH, 32'd1);
    reg_write(ftob_pkg::REG_CORE_HEIGHT, 32'd1280);
    run_random(200, -1);

    // Last phase without gaps.
    drain();
    reg_write(ftob_pkg::REG_IMAGE_WIDTH, 32'd100);
    reg_write(ftob_pkg::REG_IMAGE_HEIGHT, 32'd100);
    reg_write(ftob_pkg::REG_CORE_WIDTH, 32'd64);
    reg_write(ftob_pkg::REG_CORE_HEIGHT, 32'd20);
    idle_enable = 1'b0;
    run_random(230, -1);

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: covers the store clearing pass and the whole item stream.
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
